FILE: hw/rtl/gcct_pkg.sv
// Shared constants and types for the generalized 3x+d cycle test core.
// No dependencies.
package gcct_pkg;

   localparam int VALUE_WIDTH  = 128;
   localparam int OVERFLOW_BIT = 120;
   localparam int CNT_W        = $clog2(VALUE_WIDTH + 1);

   localparam logic [2:0] OUT_CYCLE_Y  = 3'd0;
   localparam logic [2:0] OUT_DROPPED  = 3'd1;
   localparam logic [2:0] OUT_OVERFLOW = 3'd2;
   localparam logic [2:0] OUT_UNRESOLV = 3'd3;
   localparam logic [2:0] OUT_BEYOND   = 3'd4;
   localparam logic [2:0] OUT_OTHER    = 3'd5;

   localparam logic [1:0] REG_SHIFT_D     = 2'd0;
   localparam logic [1:0] REG_RANGE_TOP   = 2'd1;
   localparam logic [1:0] REG_STEP_LIMIT  = 2'd2;
   localparam logic [1:0] REG_BRENT_LIMIT = 2'd3;

   localparam logic [39:0] PERIOD_MAX = '1;
   localparam logic [31:0] STEPS_MAX  = '1;

   typedef logic [VALUE_WIDTH-1:0] val_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_ADD  = 8'b0000_0010,
      ST_NORM = 8'b0000_0100,
      ST_POST = 8'b0000_1000,
      ST_BCHK = 8'b0001_0000,
      ST_FIN  = 8'b0010_0000,
      ST_GCD  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      PH_ORBIT  = 4'b0001,
      PH_BRENT0 = 4'b0010,
      PH_BRENT  = 4'b0100,
      PH_WALK   = 4'b1000
   } phase_type;

endpackage

FILE: hw/rtl/generalized_collatz_cycle_test_core.sv
// Top level of the generalized 3x+d cycle test core.
// Depends on gcct_pkg.
//
// Usage: the host writes shift_d, range_top, step_limit and brent_limit
// through the csr_ port while idle, then offers one odd start value on the
// req_ channel. The core follows the orbit with one shared step unit: each
// odd step computes 3x+d, removes the trailing zero bits in a normalizing
// shift of up to 8 bits per pass, and then does the compares.
// A result needs the odd steps of the orbit, plus the Brent search and one
// walk around the cycle when the step limit is hit, plus a binary gcd for a
// cycle led by y.
// One request is in flight at a time; req_stall is high from acceptance
// until the result has been taken on the rsp_ channel. While rsp_stall is
// high the result is held unchanged. Reset (synchronous) returns the core
// to idle and loads the register defaults d=1, X=1, step limit 3000 and
// Brent limit 50000000.
module generalized_collatz_cycle_test_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_start_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_outcome,
   output logic [63:0] rsp_least_element,
   output logic [39:0] rsp_period,
   output logic [31:0] rsp_odd_steps,
   output logic        rsp_primitive_res
);
   import gcct_pkg::*;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] d_ff, d_in;
   logic [63:0] top_ff, top_in;
   logic [31:0] slim_ff, slim_in;
   logic [31:0] blim_ff, blim_in;
   logic [63:0] y_ff, y_in;
   val_type     cur_ff, cur_in;
   val_type     tort_ff, tort_in;
   val_type     m_ff, m_in;
   logic [CNT_W-1:0] v_ff, v_in;
   logic [39:0] p_ff, p_in;
   logic [31:0] k_ff, k_in;
   logic [32:0] cnt_ff, cnt_in;
   logic [33:0] lam_ff, lam_in;
   logic [33:0] pow_ff, pow_in;
   logic [63:0] ga_ff, ga_in;
   logic [63:0] gb_ff, gb_in;
   logic [2:0]  oc_ff, oc_in;
   logic [63:0] le_ff, le_in;
   logic [39:0] per_ff, per_in;
   logic [31:0] odd_ff, odd_in;
   logic        prim_ff, prim_in;

   val_type     sum3;
   val_type     y_ext;
   val_type     top_ext;
   logic [2:0]  low_tz;
   logic [40:0] p_sum;
   logic [39:0] p_sat;
   logic [31:0] k_inc;
   logic        over;

   always_comb begin
      low_tz = 3'd7;
      for (int i = 6; i >= 0; i--) begin
         if (cur_ff[i]) begin
            low_tz = 3'(i);
         end
      end
   end

   assign sum3    = cur_ff + {cur_ff[VALUE_WIDTH-2:0], 1'b0} + val_type'(d_ff);
   assign y_ext   = val_type'(y_ff);
   assign top_ext = val_type'(top_ff);
   assign over    = |cur_ff[VALUE_WIDTH-1:OVERFLOW_BIT];
   assign p_sum   = {1'b0, p_ff} + 41'(v_ff);
   assign p_sat   = p_sum[40] ? PERIOD_MAX : p_sum[39:0];
   assign k_inc   = (k_ff == STEPS_MAX) ? STEPS_MAX : k_ff + 32'd1;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      d_in     = d_ff;
      top_in   = top_ff;
      slim_in  = slim_ff;
      blim_in  = blim_ff;
      y_in     = y_ff;
      cur_in   = cur_ff;
      tort_in  = tort_ff;
      m_in     = m_ff;
      v_in     = v_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      lam_in   = lam_ff;
      pow_in   = pow_ff;
      ga_in    = ga_ff;
      gb_in    = gb_ff;
      oc_in    = oc_ff;
      le_in    = le_ff;
      per_in   = per_ff;
      odd_in   = odd_ff;
      prim_in  = prim_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_SHIFT_D:     d_in    = csr_data[31:0];
            REG_RANGE_TOP:   top_in  = csr_data;
            REG_STEP_LIMIT:  slim_in = csr_data[31:0];
            REG_BRENT_LIMIT: blim_in = csr_data[31:0];
            default:         d_in    = d_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               y_in     = req_start_value;
               cur_in   = val_type'(req_start_value);
               p_in     = '0;
               k_in     = '0;
               phase_in = PH_ORBIT;
               oc_in    = OUT_CYCLE_Y;
               le_in    = '0;
               per_in   = '0;
               odd_in   = '0;
               prim_in  = 1'b0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (sum3 == '0) begin
               cur_in   = '0;
               v_in     = CNT_W'(VALUE_WIDTH);
               state_in = ST_POST;
            end else begin
               cur_in   = sum3;
               v_in     = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (cur_ff[7:0] == 8'd0) begin
               cur_in = cur_ff >> 8;
               v_in   = v_ff + CNT_W'(8);
            end else begin
               cur_in   = cur_ff >> low_tz;
               v_in     = v_ff + CNT_W'(low_tz);
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            unique case (phase_ff)
               PH_ORBIT: begin
                  p_in     = p_sat;
                  k_in     = k_inc;
                  state_in = ST_ADD;
                  if (cur_ff < y_ext) begin
                     oc_in    = OUT_DROPPED;
                     state_in = ST_DONE;
                  end else if (cur_ff == y_ext) begin
                     le_in    = y_ff;
                     per_in   = p_sat;
                     odd_in   = k_inc;
                     ga_in    = y_ff;
                     gb_in    = 64'(d_ff);
                     state_in = ST_GCD;
                  end else if (over) begin
                     oc_in    = OUT_OVERFLOW;
                     state_in = ST_DONE;
                  end else if (k_inc >= slim_ff) begin
                     tort_in  = cur_ff;
                     pow_in   = 34'd1;
                     lam_in   = 34'd1;
                     cnt_in   = '0;
                     phase_in = PH_BRENT0;
                  end
               end
               PH_BRENT0: begin
                  phase_in = PH_BRENT;
                  state_in = ST_BCHK;
               end
               PH_BRENT: begin
                  lam_in = lam_ff + 34'd1;
                  cnt_in = cnt_ff + 33'd1;
                  if (cnt_ff + 33'd1 > 33'(blim_ff)) begin
                     oc_in    = OUT_UNRESOLV;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_BCHK;
                  end
               end
               PH_WALK: begin
                  p_in = p_sat;
                  k_in = k_inc;
                  if (cur_ff < m_ff) begin
                     m_in = cur_ff;
                  end
                  state_in = (cur_ff == tort_ff) ? ST_FIN : ST_ADD;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_BCHK: begin
            if (tort_ff == cur_ff) begin
               // cycle found: tort now marks the walk's end point
               m_in     = cur_ff;
               p_in     = '0;
               k_in     = '0;
               phase_in = PH_WALK;
               state_in = ST_ADD;
            end else begin
               if (pow_ff == lam_ff) begin
                  tort_in = cur_ff;
                  pow_in  = {pow_ff[32:0], 1'b0};
                  lam_in  = '0;
               end
               if (over) begin
                  oc_in    = OUT_UNRESOLV;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_FIN: begin
            if (m_ff > top_ext) begin
               oc_in    = OUT_BEYOND;
               le_in    = (|m_ff[VALUE_WIDTH-1:64]) ? '1 : m_ff[63:0];
               per_in   = p_ff;
               odd_in   = k_ff;
               state_in = ST_DONE;
            end else if (m_ff != y_ext) begin
               oc_in    = OUT_OTHER;
               state_in = ST_DONE;
            end else begin
               oc_in    = OUT_CYCLE_Y;
               le_in    = y_ff;
               per_in   = p_ff;
               odd_in   = k_ff;
               ga_in    = y_ff;
               gb_in    = 64'(d_ff);
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // binary gcd, one subtract or halving per cycle
            if (ga_ff == '0) begin
               prim_in  = (gb_ff == 64'd1);
               state_in = ST_DONE;
            end else if (gb_ff == '0) begin
               prim_in  = (ga_ff == 64'd1);
               state_in = ST_DONE;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               prim_in  = 1'b0;
               state_in = ST_DONE;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_ORBIT;
         d_ff     <= 32'd1;
         top_ff   <= 64'd1;
         slim_ff  <= 32'd3000;
         blim_ff  <= 32'd50000000;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         d_ff     <= d_in;
         top_ff   <= top_in;
         slim_ff  <= slim_in;
         blim_ff  <= blim_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      cur_ff  <= cur_in;
      tort_ff <= tort_in;
      m_ff    <= m_in;
      v_ff    <= v_in;
      p_ff    <= p_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      lam_ff  <= lam_in;
      pow_ff  <= pow_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      oc_ff   <= oc_in;
      le_ff   <= le_in;
      per_ff  <= per_in;
      odd_ff  <= odd_in;
      prim_ff <= prim_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_outcome       = oc_ff;
   assign rsp_least_element = le_ff;
   assign rsp_period        = per_ff;
   assign rsp_odd_steps     = odd_ff;
   assign rsp_primitive_res = prim_ff;

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("ready while result pending");
   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM) |-> (cur_ff != '0))
      else $error("normalizing a zero value");
   a_lam_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BCHK) |-> (lam_ff <= pow_ff))
      else $error("brent lambda past power");
   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (oc_ff <= OUT_OTHER))
      else $error("bad outcome code");
   a_prim_only_cycle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_primitive_res) |-> (oc_ff == OUT_CYCLE_Y))
      else $error("primitive flag on non-cycle outcome");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for generalized_collatz_cycle_test_core.
// Depends on gcct_pkg and the core RTL. An in-bench orbit predictor and a
// scoreboard check every response while the request and response sides idle and stall.
module tb;
   import gcct_pkg::*;

   typedef struct {
      logic [2:0]  outcome;
      logic [63:0] least;
      logic [39:0] period;
      logic [31:0] odd_steps;
      logic        prim;
   } cycle_result_t;

   class cycle_scoreboard;
      logic [31:0] d_reg = 32'd1;
      logic [63:0] top_reg = 64'd1;
      logic [31:0] step_reg = 32'd3000;
      logic [31:0] brent_reg = 32'd50000000;
      cycle_result_t expected_q[$];
      int errors = 0;
      int checked = 0;
      int per_outcome[6] = '{default: 0};

      // x <- (3x+d) >> ctz(3x+d), returns the halving count
      function automatic int unsigned odd_step(ref val_type x);
         val_type u;
         int unsigned v;
         u = x * 3 + val_type'(d_reg);
         if (u == '0) begin
            x = '0;
            return VALUE_WIDTH;
         end
         v = 0;
         while (!u[v]) v++;
         x = u >> v;
         return v;
      endfunction

      function automatic logic coprime(logic [63:0] a, logic [63:0] b);
         logic [63:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a == 64'd1;
      endfunction

      function automatic cycle_result_t predict_orbit(logic [63:0] y);
         cycle_result_t r;
         val_type yv, x, m, z, hare, tort;
         logic [63:0] k, p, pp, aa, power, lam, cnt;
         r = '{OUT_CYCLE_Y, 64'd0, 40'd0, 32'd0, 1'b0};
         yv = val_type'(y);
         x = yv;
         k = 0; p = 0; pp = 0; aa = 0; power = 1; lam = 1; cnt = 0;
         forever begin
            p += odd_step(x);
            k++;
            if (x < yv) begin
               r.outcome = OUT_DROPPED;
               return r;
            end
            if (x == yv) begin
               r.least = y;
               r.period = (p > PERIOD_MAX) ? PERIOD_MAX : p[39:0];
               r.odd_steps = (k > STEPS_MAX) ? STEPS_MAX : k[31:0];
               r.prim = coprime(y, d_reg);
               return r;
            end
            if (|x[VALUE_WIDTH-1:OVERFLOW_BIT]) begin
               r.outcome = OUT_OVERFLOW;
               return r;
            end
            if (k >= step_reg) break;
         end
         tort = x;
         hare = x;
         void'(odd_step(hare));
         while (tort != hare) begin
            if (power == lam) begin
               tort = hare;
               power <<= 1;
               lam = 0;
            end
            if (|hare[VALUE_WIDTH-1:OVERFLOW_BIT]) begin
               r.outcome = OUT_UNRESOLV;
               return r;
            end
            void'(odd_step(hare));
            lam++;
            cnt++;
            if (cnt > brent_reg) begin
               r.outcome = OUT_UNRESOLV;
               return r;
            end
         end
         m = hare;
         z = hare;
         do begin
            pp += odd_step(z);
            aa++;
            if (z < m) m = z;
         end while (z != hare);
         if (m > val_type'(top_reg)) begin
            r.outcome = OUT_BEYOND;
            r.least = (m[VALUE_WIDTH-1:64] == '0) ? m[63:0] : '1;
         end else if (m != yv) begin
            r.outcome = OUT_OTHER;
            return r;
         end else begin
            r.least = y;
            r.prim = coprime(y, d_reg);
         end
         r.period = (pp > PERIOD_MAX) ? PERIOD_MAX : pp[39:0];
         r.odd_steps = (aa > STEPS_MAX) ? STEPS_MAX : aa[31:0];
         return r;
      endfunction

      function void note_request(logic [63:0] y);
         expected_q.push_back(predict_orbit(y));
      endfunction

      function void check_result(cycle_result_t got);
         cycle_result_t want;
         if (expected_q.size() == 0) begin
            $error("response with no request pending");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.outcome < 6) per_outcome[want.outcome]++;
         if (got.outcome !== want.outcome) begin
            $error("outcome exp %0d got %0d", want.outcome, got.outcome);
            errors++;
         end
         if (got.least !== want.least) begin
            $error("least_element exp %0h got %0h", want.least, got.least);
            errors++;
         end
         if (got.period !== want.period) begin
            $error("period exp %0d got %0d", want.period, got.period);
            errors++;
         end
         if (got.odd_steps !== want.odd_steps) begin
            $error("odd_steps exp %0d got %0d", want.odd_steps, got.odd_steps);
            errors++;
         end
         if (got.prim !== want.prim) begin
            $error("primitive_res exp %0b got %0b", want.prim, got.prim);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = REG_SHIFT_D;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_start_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_outcome;
   logic [63:0] rsp_least_element;
   logic [39:0] rsp_period;
   logic [31:0] rsp_odd_steps;
   logic        rsp_primitive_res;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   cycle_scoreboard sb = new();

   generalized_collatz_cycle_test_core dut (.*);

   always #6 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_outcome, rsp_least_element, rsp_period,
                           rsp_odd_steps, rsp_primitive_res});
   end

   initial begin
      #(12 * 40_000_000);
      $display("tb: FAIL");
      $finish;
   end

   task automatic offer(input logic [63:0] y);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_start_value = y;
      do @(posedge clock); while (req_stall);
      sb.note_request(y);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_SHIFT_D:     sb.d_reg = value[31:0];
         REG_RANGE_TOP:   sb.top_reg = value;
         REG_STEP_LIMIT:  sb.step_reg = value[31:0];
         REG_BRENT_LIMIT: sb.brent_reg = value[31:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] d, input logic [63:0] top,
                            input logic [31:0] steps, input logic [31:0] brent);
      drain();
      write_reg(REG_SHIFT_D, {32'd0, d});
      write_reg(REG_RANGE_TOP, top);
      write_reg(REG_STEP_LIMIT, {32'd0, steps});
      write_reg(REG_BRENT_LIMIT, {32'd0, brent});
   endtask

   function automatic logic [63:0] pick_start(bit no_zero);
      logic [63:0] y;
      case ($urandom_range(3))
         0: y = 64'($urandom_range(2000));
         1: y = {$urandom, $urandom};
         2: y = {$urandom, $urandom} >> $urandom_range(63);
         default: y = 64'($urandom_range(300)) * 2 + 1;
      endcase
      if ($urandom_range(9) != 0) y[0] = 1'b1;
      if (no_zero && y < 2) y = 64'd3;
      return y;
   endfunction

   // random requests in chunks that rotate through the idling modes
   task automatic random_run(input int count, input bit no_zero);
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            case ((i / 25) % 5)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 64; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 64; end
               3: begin idle_pct = 32; stall_pct = 32; end
               default: begin idle_pct = 0; stall_pct = 0; end
            endcase
         end
         offer(pick_start(no_zero));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // register defaults: plain 3x+1
      offer(64'd1);
      offer(64'd3);
      offer(64'd27);
      offer(64'd0);
      offer(64'd2);
      offer(64'hFFFF_FFFF_FFFF_FFFF);
      offer(64'h8000_0000_0000_0000);
      offer(64'h5555_5555_5555_5555);

      // d=5: small cycles, one led by 187 longer than the step limit
      configure(32'd5, 64'd10, 32'd8, 32'd200);
      offer(64'd1);
      offer(64'd19);
      offer(64'd23);
      offer(64'd187);
      offer(64'd0);
      offer(64'd10);
      random_run(110, 1'b0);

      // lowest limits
      configure(32'd7, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd1);
      offer(64'd1);
      offer(64'd3);
      offer(64'd5);
      offer(64'hFFFF_FFFF_FFFF_FFFF);
      random_run(115, 1'b0);

      configure(32'hFFFF_FFFF, 64'd1, 32'd20, 32'd300);
      offer(64'd1);
      offer(64'hFFFF_FFFF_FFFF_FFFE);
      random_run(50, 1'b0);
      // long response hold-off while requests keep coming
      hold_cycles = 400;
      random_run(30, 1'b0);
      drain();
      random_run(35, 1'b0);

      // highest limits: odd 3x+1 orbits always terminate early
      configure(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_run(115, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         configure(32'($urandom_range(500)) * 2 + 1, {$urandom, $urandom} >> $urandom_range(63),
                   32'($urandom_range(1, 40)), 32'($urandom_range(1, 300)));
         random_run(30, 1'b0);
      end

      drain();
      repeat (20) @(negedge clock);
      $display("tb: %0d responses checked; outcomes 0..5 seen %0d/%0d/%0d/%0d/%0d/%0d",
               sb.checked, sb.per_outcome[0], sb.per_outcome[1], sb.per_outcome[2],
               sb.per_outcome[3], sb.per_outcome[4], sb.per_outcome[5]);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end
endmodule

FILE: generalized_collatz_cycle_test_core.f
hw/rtl/gcct_pkg.sv
hw/rtl/generalized_collatz_cycle_test_core.sv
tb/tb.sv
